/* rtl/core/assert_macros.svh */
// Assertion helper macros for the SHA-512 core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/sha512_pkg.sv */
// Shared types, constants and functions for the SHA-512 core.
// No dependencies.
`default_nettype none
package sha512_pkg;
	localparam int WordW = 64;
	localparam int Rounds = 80;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
	} state_t;

	// Request to the round unit from the sequencer.
	typedef struct packed {
		logic load;
		logic step;
		logic sched;
		logic add;
	} rnd_ctl_t;

	localparam logic [WordW-1:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	localparam logic [WordW-1:0] K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

	function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction
endpackage
`default_nettype wire

/* rtl/core/sha512_round.sv */
// SHA-512 round unit: working variables, chaining value and 16-word schedule.
// Depends on sha512_pkg. One round per step request.
`default_nettype none
`include "assert_macros.svh"
module sha512_round
	import sha512_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rnd_ctl_t         ctl,
	input  wire logic             init,
	input  wire logic [6:0]       round,
	input  wire logic             wr_en,
	input  wire logic [3:0]       wr_idx,
	input  wire logic [WordW-1:0] wr_data,
	input  wire logic [2:0]       rd_idx,
	output logic      [WordW-1:0] rd_data
);
	logic [WordW-1:0] v_q [8];
	logic [WordW-1:0] h_q [8];
	logic [WordW-1:0] w_q [16];
	logic [3:0] t4;
	logic [WordW-1:0] x15, x2, s0, s1, w_new, w_cur, t1, t2;

	// Schedule expansion and round function.
	always_comb begin
		t4 = round[3:0];
		x15 = w_q[t4 + 4'd1];
		x2 = w_q[t4 + 4'd14];
		s0 = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
		s1 = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
		w_new = w_q[t4] + s0 + s1 + w_q[t4 + 4'd9];
		w_cur = ctl.sched ? w_new : w_q[t4];
		t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + K[round] + w_cur;
		t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign rd_data = h_q[rd_idx];

	// Schedule window, written by the loader or by expansion.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[wr_idx] <= wr_data;
		end else if (ctl.step && ctl.sched) begin
			w_q[t4] <= w_new;
		end
	end

	// Working variables and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= IV[i];
				h_q[i] <= IV[i];
			end
		end else if (init) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= IV[i];
				h_q[i] <= IV[i];
			end
		end else if (ctl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.step) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	`CHK_IMPL(a_one_op, clk, arst_n, 1'b1, $countones({ctl.load, ctl.step, ctl.add}) <= 1)
	`CHK_IMPL(a_sched_late, clk, arst_n, ctl.step && ctl.sched, round >= 7'd16)
	`CHK_IMPL(a_round_rng, clk, arst_n, ctl.step, round < 7'd80)
endmodule
`default_nettype wire

/* rtl/core/sha512_hash_top.sv */
// SHA-512 hasher top level: stream ports, padding sequencer, digest output.
// Depends on sha512_pkg and sha512_round.
//
// Usage: message words enter on s_axis (tdata holds data_word, tuser holds
// valid_bytes, tlast marks the final word). Each accepted word is written to
// the schedule window as it is accepted; every sixteenth word starts a block
// of 80 rounds, one round per cycle in the shared round unit, plus a load step
// and a feed-forward step; s_axis_tready is low for the whole block.
// After tlast, the sequencer writes padding words one per cycle, pausing while
// a block runs, runs the final block or two, then presents eight digest words
// on m_axis, word 0 first, tlast on word 7. Output holds while m_axis_tready
// is low; no new request is accepted until the eighth word is taken. After
// that all state is back at its reset value. Reset (arst_n low) sets the
// chaining value to IV, clears the byte count and returns the block to idle.
`default_nettype none
`include "assert_macros.svh"
module sha512_hash_top
	import sha512_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] data_word
	input  wire logic [3:0]  s_axis_tuser,  // [3:0] valid_bytes
	input  wire logic        s_axis_tlast,  // last_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // [63:0] digest_word
	output logic [2:0]       m_axis_tuser,  // [2:0] word_index
	output logic             m_axis_tlast   // digest_last
);
	state_t state_q, state_d;
	logic [6:0] round_q;
	logic [3:0] wib_q;
	logic [60:0] bytes_q;
	logic [2:0] oidx_q;
	logic pad_done_q;    // final block carries the length
	logic need80_q;      // 0x80 marker still to be written
	logic final_q;       // message ended, padding in progress
	logic len_room_q;    // the current block still has room for the length word
	rnd_ctl_t ctl;
	logic init, wr_en, acc;
	logic [3:0] wr_idx;
	logic [63:0] wr_data, in_word, keep, mark, len_bits;
	logic [3:0] nb;
	logic [60:0] bytes_n;
	logic [63:0] hout;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign nb = (!s_axis_tlast || s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;
	assign bytes_n = bytes_q + 61'(nb);
	assign len_bits = {bytes_q, 3'b000};

	// Mask partial final words and place the 0x80 marker.
	always_comb begin
		keep = (nb == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {nb, 3'b000});
		mark = (nb == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {nb, 3'b000}));
		in_word = (s_axis_tdata & keep) | mark;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc) begin
				if (wib_q == 4'd15) state_d = ST_ROUND;
				else if (s_axis_tlast) state_d = ST_PAD;
			end
			ST_PAD: if (wib_q == 4'd15) state_d = ST_ROUND;
			ST_ROUND: if (round_q == 7'(Rounds)) state_d = ST_ADD;
			ST_ADD: state_d = pad_done_q ? ST_OUT : (final_q ? ST_PAD : ST_IDLE);
			ST_OUT: if (m_axis_tready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		ctl = '0;
		wr_en = 1'b0;
		wr_idx = wib_q;
		wr_data = in_word;
		init = 1'b0;
		case (state_q)
			ST_IDLE: wr_en = acc;
			ST_PAD: begin
				wr_en = 1'b1;
				if (need80_q) wr_data = 64'h8000_0000_0000_0000;
				else if (wib_q == 4'd15 && len_room_q) wr_data = len_bits;
				else wr_data = 64'd0;
			end
			ST_ROUND: begin
				ctl.load = (round_q == 7'd0);
				ctl.step = (round_q != 7'd0);
				ctl.sched = (round_q > 7'd16);
			end
			ST_ADD: ctl.add = 1'b1;
			ST_OUT: init = m_axis_tready && oidx_q == 3'd7;
			default: ;
		endcase
	end

	sha512_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .init(init),
		.round(round_q == 7'd0 ? 7'd0 : round_q - 7'd1),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.rd_idx(oidx_q), .rd_data(hout)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			wib_q <= '0;
			bytes_q <= '0;
			oidx_q <= '0;
			pad_done_q <= 1'b0;
			need80_q <= 1'b0;
			final_q <= 1'b0;
			len_room_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) round_q <= (round_q == 7'(Rounds)) ? 7'd0 : round_q + 7'd1;
			if (wr_en) wib_q <= wib_q + 4'd1;
			if (acc) begin
				bytes_q <= bytes_n;
				if (s_axis_tlast) begin
					final_q <= 1'b1;
					need80_q <= (nb == 4'd8);
					// A marker in word 14 leaves no room for the length in this block.
					len_room_q <= (wib_q != 4'd14);
				end
			end
			if (state_q == ST_PAD) begin
				need80_q <= 1'b0;
				if (need80_q) begin
					len_room_q <= (wib_q != 4'd14);
				end else if (wib_q == 4'd15) begin
					if (len_room_q) pad_done_q <= 1'b1;
					else len_room_q <= 1'b1;
				end
			end
			// The index wraps to zero after the eighth digest word.
			if (state_q == ST_OUT && m_axis_tready) oidx_q <= oidx_q + 3'd1;
			if (init) begin
				bytes_q <= '0;
				pad_done_q <= 1'b0;
				final_q <= 1'b0;
				len_room_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = hout;
	assign m_axis_tuser = oidx_q;
	assign m_axis_tlast = (oidx_q == 3'd7);

	`CHK_IMPL(a_no_in_busy, clk, arst_n, state_q != ST_IDLE, !s_axis_tready)
	`CHK_IMPL(a_out_idle, clk, arst_n, state_q != ST_OUT, !m_axis_tvalid)
	`CHK_NEXT(a_round_done, clk, arst_n, state_q == ST_ROUND && round_q == 7'(Rounds),
		state_q == ST_ADD)
	`CHK_NEXT(a_clear, clk, arst_n, init, bytes_q == 61'd0 && wib_q == 4'd0)
endmodule
`default_nettype wire

/* bench/sha512_hash_chk.sv */
// Digest checker for the SHA-512 hasher: watches both streams, hashes each
// accepted message word itself, and compares every digest word in order.
// Depends on sha512_pkg for the word width only.
`timescale 1ns / 1ps
module sha512_hash_chk
	import sha512_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic [3:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending_words,
	output int          digests_seen
);
	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  index;
		logic        is_last;
	} digest_item_t;

	localparam logic [63:0] HINIT [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	localparam logic [63:0] RK [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

	logic [WordW-1:0] chain [8];
	logic [63:0]      block_words [16];
	logic [3:0]       fill_pos;
	logic [60:0]      byte_total;
	digest_item_t     digest_queue [$];

	function automatic logic [63:0] ror64(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// One 128-byte block: 80 rounds with a rolling schedule, then feed-forward.
	task automatic compress_block();
		logic [63:0] v [8];
		logic [63:0] w [16];
		logic [63:0] x15, x2, t1, t2;
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 16; i++) w[i] = block_words[i];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				x15 = w[(t - 15) & 15];
				x2 = w[(t - 2) & 15];
				w[t & 15] += (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7))
					+ (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6)) + w[(t - 7) & 15];
			end
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t & 15];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endtask

	task automatic append_word(logic [63:0] w);
		block_words[fill_pos] = w;
		fill_pos = fill_pos + 1;
		if (fill_pos == 0)
			compress_block();
	endtask

	task automatic clear_hash();
		for (int i = 0; i < 8; i++) chain[i] = HINIT[i];
		fill_pos = 0;
		byte_total = 0;
	endtask

	// Absorb one accepted request; on the final word pad and queue the digest.
	task automatic absorb_request(logic [63:0] data, logic [3:0] nb_in, logic fin);
		int nb;
		logic [63:0] keep;
		nb = (nb_in > 8 || !fin) ? 8 : nb_in;
		byte_total = byte_total + 61'(nb);
		if (!fin) begin
			append_word(data);
			return;
		end
		if (nb == 8) begin
			append_word(data);
			append_word(64'h80 << 56);
		end else begin
			keep = (nb == 0) ? 64'd0 : ~64'd0 << (64 - 8 * nb);
			append_word((data & keep) | (64'h80 << (56 - 8 * nb)));
		end
		while (fill_pos != 14) append_word(64'd0);
		append_word(64'd0);
		append_word({byte_total, 3'b000});
		for (int i = 0; i < 8; i++)
			digest_queue.push_back('{chain[i], 3'(i), i == 7});
		clear_hash();
	endtask

	assign pending_words = digest_queue.size();

	// Predict on input requests and compare output requests at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		digest_item_t exp_item;
		if (!arst_n) begin
			clear_hash();
			digest_queue.delete();
			fail_count <= 0;
			digests_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest word %h idx %0d", $time,
						m_axis_tdata, m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					exp_item = digest_queue.pop_front();
					if (exp_item.word !== m_axis_tdata || exp_item.index !== m_axis_tuser
						|| exp_item.is_last !== m_axis_tlast) begin
						$display("%0t: digest mismatch expected %h/%0d/%0d got %h/%0d/%0d",
							$time, exp_item.word, exp_item.index, exp_item.is_last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
						fail_count <= fail_count + 1;
					end
					if (exp_item.is_last)
						digests_seen <= digests_seen + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
		end
	end
endmodule

/* bench/tb.sv */
// Top of the SHA-512 hasher testbench: clock, reset, message stimulus,
// receiver stalls and verdict. Depends on sha512_hash_top and sha512_hash_chk.
`timescale 1ns / 1ps
module tb;
	typedef struct {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        fin;
	} msg_word_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          fail_count, pending_words, digests_seen;
	int          words_sent = 0;
	bit          hold_off = 0;
	msg_word_t   send_queue [$];

	always #5 clk = ~clk;

	sha512_hash_top uut (.*);
	sha512_hash_chk chk (.*);

	// Queue one message; full words are random, or all ones when ones is set; the final one is shaped by args.
	task automatic queue_message(int n_full, logic [3:0] last_nb, bit ones);
		for (int i = 0; i < n_full; i++)
			send_queue.push_back('{ones ? ~64'd0 : {$urandom, $urandom},
				4'($urandom), 1'b0});
		send_queue.push_back('{ones ? ~64'd0 : {$urandom, $urandom}, last_nb, 1'b1});
	endtask

	// Present every queued request in bursts with random gaps.
	task automatic drain_queue();
		msg_word_t m;
		int burst;
		burst = $urandom_range(1, 12);
		while (send_queue.size() > 0) begin
			m = send_queue.pop_front();
			s_axis_tvalid <= 1;
			s_axis_tdata <= m.data;
			s_axis_tuser <= m.nbytes;
			s_axis_tlast <= m.fin;
			do @(posedge clk); while (!s_axis_tready);
			words_sent++;
			@(negedge clk);
			if (--burst == 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst = $urandom_range(1, 12);
			end
		end
		s_axis_tvalid <= 0;
	endtask

	// Receiver: stalls on its own pattern, with stall-free stretches and one long hold.
	initial begin
		int phase;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			phase = (phase + 1) % 200;
			if (hold_off)
				m_axis_tready <= 0;
			else if (phase < 50)
				m_axis_tready <= 1;
			else
				m_axis_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: empty message, all-ones words, each tail length, oversized counts,
		// an exact 112-byte boundary that forces a second padding block.
		queue_message(0, 4'd0, 0);
		queue_message(0, 4'd8, 1);
		queue_message(1, 4'd15, 1);
		queue_message(0, 4'd9, 0);
		for (int nb = 1; nb < 8; nb++) queue_message(0, 4'(nb), 0);
		queue_message(13, 4'd8, 0);
		drain_queue();

		// Wait for every digest before going on.
		while (pending_words != 0) @(negedge clk);

		// Long receiver hold while the sender keeps offering two messages.
		hold_off = 1;
		queue_message(3, 4'd4, 0);
		queue_message(2, 4'd8, 0);
		fork
			drain_queue();
			begin
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
		join

		// Random messages, mostly short, a few over several blocks.
		while (words_sent < 265) begin
			if ($urandom_range(0, 9) == 0)
				queue_message($urandom_range(15, 40), 4'($urandom), 0);
			else
				queue_message($urandom_range(0, 10), 4'($urandom_range(0, 8)), 0);
			drain_queue();
			if ($urandom_range(0, 4) == 0)
				while (pending_words != 0) @(negedge clk);
		end

		while (pending_words != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d message words; %0d digests checked.", words_sent, digests_seen);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sha512_pkg.sv
rtl/core/sha512_round.sv
rtl/core/sha512_hash_top.sv
bench/sha512_hash_chk.sv
bench/tb.sv
